/* sv/tbpf_pkg.sv */
// Shared types, codes and the multiply sequence table of the track boundary point filter.
`default_nettype none
package tbpf_pkg;

  localparam int FENCE_DEPTH_DEF = 4096;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int FIELD_W    = 32;
  localparam int CMD_W      = 2;
  localparam int VIDX_W     = 12;
  localparam int CI_W       = 12;
  localparam int FC_W       = 13;
  localparam int MARGIN_W   = 16;
  localparam int M2_W       = 2 * MARGIN_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 4;

  localparam logic [CMD_W-1:0] CMD_LOAD_INNER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_OUTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOSEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FENCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd2;

  localparam logic [FC_W-1:0]     FENCE_RST  = 13'd2;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd384;

  localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

  typedef enum logic [3:0] {
    MP_PAX_DX, MP_PAY_DY, MP_PBX_DX, MP_PBY_DY, MP_PAX_PBY, MP_PAY_PBX,
    MP_DX_DX, MP_DY_DY, MP_MG_MG, MP_CRH_CRH, MP_CRH_CRL, MP_CRL_CRL,
    MP_M2_LENL, MP_M2_LENH
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_LOADNEG, ACC_ADD, ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {SH_0, SH_H, SH_H1, SH_2H} sh_sel_t;

  typedef enum logic [2:0] {LT_NONE, LT_P1, LT_P2, LT_CR, LT_LEN, LT_M2} lat_t;

  typedef struct packed {
    mul_sel_t mp;
    acc_op_t  acc;
    sh_sel_t  sh;
    lat_t     lt;
  } uop_t;

  typedef struct packed {
    logic       capture;
    logic       start;
    logic       rd_en;
    logic [1:0] off;
    logic       outer;
    logic       cap_a;
    logic       diff;
    logic       emit;
    uop_t       uop;
  } ctl_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic seg_ok;
  } ctl_sts_t;

  // One segment: projections, cross product, length, then cr^2 - m^2*len^2.
  // A latch reads the accumulator once the last product it needs has been registered and accumulated.
  function automatic uop_t step_uop(logic [STEP_W-1:0] step);
    uop_t u;
    u = '{mp: MP_PAX_DX, acc: ACC_HOLD, sh: SH_0, lt: LT_NONE};
    unique case (step)
      4'd0:  u = '{mp: MP_PAX_DX,  acc: ACC_LOAD,    sh: SH_0,  lt: LT_NONE};
      4'd1:  u = '{mp: MP_PAY_DY,  acc: ACC_ADD,     sh: SH_0,  lt: LT_NONE};
      4'd2:  u = '{mp: MP_PBX_DX,  acc: ACC_LOADNEG, sh: SH_0,  lt: LT_NONE};
      4'd3:  u = '{mp: MP_PBY_DY,  acc: ACC_SUB,     sh: SH_0,  lt: LT_P1};
      4'd4:  u = '{mp: MP_PAX_PBY, acc: ACC_LOAD,    sh: SH_0,  lt: LT_NONE};
      4'd5:  u = '{mp: MP_PAY_PBX, acc: ACC_SUB,     sh: SH_0,  lt: LT_P2};
      4'd6:  u = '{mp: MP_DX_DX,   acc: ACC_LOAD,    sh: SH_0,  lt: LT_NONE};
      4'd7:  u = '{mp: MP_DY_DY,   acc: ACC_ADD,     sh: SH_0,  lt: LT_CR};
      4'd8:  u = '{mp: MP_MG_MG,   acc: ACC_LOAD,    sh: SH_0,  lt: LT_NONE};
      4'd9:  u = '{mp: MP_CRH_CRH, acc: ACC_LOAD,    sh: SH_2H, lt: LT_LEN};
      4'd10: u = '{mp: MP_CRH_CRL, acc: ACC_ADD,     sh: SH_H1, lt: LT_M2};
      4'd11: u = '{mp: MP_CRL_CRL, acc: ACC_ADD,     sh: SH_0,  lt: LT_NONE};
      4'd12: u = '{mp: MP_M2_LENL, acc: ACC_SUB,     sh: SH_0,  lt: LT_NONE};
      4'd13: u = '{mp: MP_M2_LENH, acc: ACC_SUB,     sh: SH_H,  lt: LT_NONE};
      default: u = '{mp: MP_PAX_DX, acc: ACC_HOLD, sh: SH_0, lt: LT_NONE};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* sv/tbpf_addr.sv */
// Vertex index generator: wrap count, centre index reduction and segment end indices.
`default_nettype none
module tbpf_addr #(
  parameter int FENCE_DEPTH = tbpf_pkg::FENCE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [tbpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tbpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire tbpf_pkg::ctl_cmd_t                  cmd,
  output logic                                     mod_done,
  output logic [$clog2(FENCE_DEPTH)-1:0]           rd_index
);

  localparam int IW = $clog2(FENCE_DEPTH);
  localparam int NW = (IW + 1 > tbpf_pkg::FC_W) ? IW + 1 : tbpf_pkg::FC_W;
  localparam int XW = NW + 1;
  localparam int CNT_W = $clog2(tbpf_pkg::CI_W);

  logic [tbpf_pkg::CI_W-1:0] ci_r;
  logic [tbpf_pkg::FC_W-1:0] fc_r;
  logic [IW-1:0]             c_r;
  logic [NW-1:0]             rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;

  logic [NW-1:0] n_eff;
  logic [NW:0]   rem_sh;
  logic [NW-1:0] rem_nxt;
  logic [XW-1:0] u;
  logic [XW-1:0] v;

  // Clamp the count to the table.
  always_comb begin
    priority if (fc_r < tbpf_pkg::FC_W'(2)) begin
      n_eff = NW'(2);
    end else if (NW'(fc_r) > NW'(FENCE_DEPTH)) begin
      n_eff = NW'(FENCE_DEPTH);
    end else begin
      n_eff = NW'(fc_r);
    end
  end

  // One restoring remainder step per cycle.
  always_comb begin
    rem_sh = {rem_r, ci_r[cnt_r]};
    if (rem_sh >= (NW + 1)'(n_eff)) begin
      rem_nxt = NW'(rem_sh - (NW + 1)'(n_eff));
    end else begin
      rem_nxt = NW'(rem_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r   <= '0;
      fc_r   <= tbpf_pkg::FENCE_RST;
      busy_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      c_r    <= '0;
    end else begin
      if (cfg_we && cfg_index == tbpf_pkg::CFG_CLOSEST) begin
        ci_r <= cfg_wdata[tbpf_pkg::CI_W-1:0];
      end
      if (cfg_we && cfg_index == tbpf_pkg::CFG_FENCE) begin
        fc_r <= cfg_wdata[tbpf_pkg::FC_W-1:0];
      end
      if (cmd.start) begin
        if (NW'(ci_r) < n_eff) begin
          c_r <= IW'(ci_r);
        end else begin
          busy_r <= 1'b1;
          rem_r  <= '0;
          cnt_r  <= CNT_W'(tbpf_pkg::CI_W - 1);
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        if (cnt_r == '0) begin
          c_r    <= IW'(rem_nxt);
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign mod_done = !busy_r;

  // Index is centre + off - 2, wrapped once either way.
  always_comb begin
    u = XW'(c_r) + XW'(cmd.off);
    v = u - XW'(2);
    priority if (u < XW'(2)) begin
      rd_index = IW'(u + XW'(n_eff) - XW'(2));
    end else if (v >= XW'(n_eff)) begin
      rd_index = IW'(v - XW'(n_eff));
    end else begin
      rd_index = IW'(v);
    end
  end

`ifndef SYNTHESIS
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (NW'(rd_index) < n_eff))
    else $error("vertex index beyond wrap count");
`endif

endmodule
`default_nettype wire

/* sv/tbpf_dp.sv */
// Datapath: vertex tables, point registers, shared multiplier and wide accumulator.
`default_nettype none
module tbpf_dp #(
  parameter int FENCE_DEPTH = tbpf_pkg::FENCE_DEPTH_DEF,
  parameter int COORD_WIDTH = tbpf_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [tbpf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tbpf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire logic [tbpf_pkg::CMD_W-1:0]             in_command,
  input  wire logic [tbpf_pkg::VIDX_W-1:0]            in_vertex_index,
  input  wire logic signed [tbpf_pkg::FIELD_W-1:0]    in_coord_x,
  input  wire logic signed [tbpf_pkg::FIELD_W-1:0]    in_coord_y,
  input  wire logic signed [tbpf_pkg::FIELD_W-1:0]    in_coord_z,
  input  wire tbpf_pkg::ctl_cmd_t                     cmd,
  input  wire logic [$clog2(FENCE_DEPTH)-1:0]         rd_index,
  output logic                                        seg_ok,
  output logic signed [tbpf_pkg::FIELD_W-1:0]         out_x,
  output logic signed [tbpf_pkg::FIELD_W-1:0]         out_y,
  output logic signed [tbpf_pkg::FIELD_W-1:0]         out_z
);

  localparam int CW = COORD_WIDTH;
  localparam int IW = $clog2(FENCE_DEPTH);
  localparam int VW = ((IW > tbpf_pkg::VIDX_W) ? IW : tbpf_pkg::VIDX_W) + 1;
  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int H  = CW + 1;
  localparam int MW = (CW + 2 > tbpf_pkg::M2_W + 1) ? CW + 2 : tbpf_pkg::M2_W + 1;
  localparam int AW = 4 * CW + 6;

  logic [2*CW-1:0] inner_mem [FENCE_DEPTH];
  logic [2*CW-1:0] outer_mem [FENCE_DEPTH];
  logic [2*CW-1:0] rd_in_r;
  logic [2*CW-1:0] rd_out_r;
  logic [2*CW-1:0] a_r;

  logic [tbpf_pkg::MARGIN_W-1:0] margin_r;
  logic signed [CW-1:0] px_r;
  logic signed [CW-1:0] py_r;
  logic signed [tbpf_pkg::FIELD_W-1:0] pz_r;

  logic signed [DW-1:0] dx_r, dy_r, pax_r, pay_r, pbx_r, pby_r;

  logic signed [MW-1:0]   opa, opb;
  logic signed [2*MW-1:0] prod_r;
  tbpf_pkg::acc_op_t      acc_op_r;
  tbpf_pkg::sh_sel_t      sh_r;
  logic signed [AW-1:0]   ext;
  logic signed [AW-1:0]   shifted;
  logic signed [AW-1:0]   acc_r;
  logic signed [AW-1:0]   acc_neg;

  logic [PW-1:0]                 crmag_r;
  logic [PW-1:0]                 len_r;
  logic [tbpf_pkg::M2_W-1:0]     m2_r;
  logic                          p1_r, p2_r, side_r;
  logic                          acc_pos;

  logic [2*CW-1:0]      vert;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic [VW-1:0]        widx_w;
  logic                 wr_inner, wr_outer;

  assign widx_w   = VW'(in_vertex_index);
  assign wr_inner = cmd.capture && in_command == tbpf_pkg::CMD_LOAD_INNER
                    && widx_w < VW'(FENCE_DEPTH);
  assign wr_outer = cmd.capture && in_command == tbpf_pkg::CMD_LOAD_OUTER
                    && widx_w < VW'(FENCE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_inner) begin
      inner_mem[IW'(in_vertex_index)] <= {in_coord_y[CW-1:0], in_coord_x[CW-1:0]};
    end
    if (wr_outer) begin
      outer_mem[IW'(in_vertex_index)] <= {in_coord_y[CW-1:0], in_coord_x[CW-1:0]};
    end
    if (cmd.rd_en) begin
      rd_in_r  <= inner_mem[rd_index];
      rd_out_r <= outer_mem[rd_index];
    end
  end

  assign vert = cmd.outer ? rd_out_r : rd_in_r;
  assign ax   = a_r[CW-1:0];
  assign ay   = a_r[2*CW-1:CW];
  assign bx   = vert[CW-1:0];
  assign by   = vert[2*CW-1:CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= tbpf_pkg::MARGIN_RST;
    end else if (cfg_we && cfg_index == tbpf_pkg::CFG_MARGIN) begin
      margin_r <= cfg_wdata[tbpf_pkg::MARGIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= in_coord_x[CW-1:0];
      py_r <= in_coord_y[CW-1:0];
      pz_r <= in_coord_z;
    end
    if (cmd.cap_a) begin
      a_r <= vert;
    end
    if (cmd.diff) begin
      dx_r  <= DW'(bx) - DW'(ax);
      dy_r  <= DW'(by) - DW'(ay);
      pax_r <= DW'(px_r) - DW'(ax);
      pay_r <= DW'(py_r) - DW'(ay);
      pbx_r <= DW'(px_r) - DW'(bx);
      pby_r <= DW'(py_r) - DW'(by);
    end
    if (cmd.emit) begin
      out_x <= tbpf_pkg::FIELD_W'(px_r);
      out_y <= tbpf_pkg::FIELD_W'(py_r);
      out_z <= pz_r;
    end
  end

  always_comb begin
    unique case (cmd.uop.mp)
      tbpf_pkg::MP_PAX_DX:  begin opa = MW'(pax_r); opb = MW'(dx_r);  end
      tbpf_pkg::MP_PAY_DY:  begin opa = MW'(pay_r); opb = MW'(dy_r);  end
      tbpf_pkg::MP_PBX_DX:  begin opa = MW'(pbx_r); opb = MW'(dx_r);  end
      tbpf_pkg::MP_PBY_DY:  begin opa = MW'(pby_r); opb = MW'(dy_r);  end
      tbpf_pkg::MP_PAX_PBY: begin opa = MW'(pax_r); opb = MW'(pby_r); end
      tbpf_pkg::MP_PAY_PBX: begin opa = MW'(pay_r); opb = MW'(pbx_r); end
      tbpf_pkg::MP_DX_DX:   begin opa = MW'(dx_r);  opb = MW'(dx_r);  end
      tbpf_pkg::MP_DY_DY:   begin opa = MW'(dy_r);  opb = MW'(dy_r);  end
      tbpf_pkg::MP_MG_MG:   begin opa = MW'(margin_r); opb = MW'(margin_r); end
      tbpf_pkg::MP_CRH_CRH: begin
        opa = MW'(crmag_r[PW-1:H]); opb = MW'(crmag_r[PW-1:H]);
      end
      tbpf_pkg::MP_CRH_CRL: begin
        opa = MW'(crmag_r[PW-1:H]); opb = MW'(crmag_r[H-1:0]);
      end
      tbpf_pkg::MP_CRL_CRL: begin
        opa = MW'(crmag_r[H-1:0]); opb = MW'(crmag_r[H-1:0]);
      end
      tbpf_pkg::MP_M2_LENL: begin opa = MW'(m2_r); opb = MW'(len_r[H-1:0]);  end
      tbpf_pkg::MP_M2_LENH: begin opa = MW'(m2_r); opb = MW'(len_r[PW-1:H]); end
      default:              begin opa = '0; opb = '0; end
    endcase
  end

  assign ext = AW'(prod_r);

  always_comb begin
    unique case (sh_r)
      tbpf_pkg::SH_0:  shifted = ext;
      tbpf_pkg::SH_H:  shifted = ext <<< H;
      tbpf_pkg::SH_H1: shifted = ext <<< (H + 1);
      tbpf_pkg::SH_2H: shifted = ext <<< (2 * H);
      default:         shifted = ext;
    endcase
  end

  assign acc_neg = -acc_r;
  assign acc_pos = !acc_r[AW-1] && (acc_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_op_r <= tbpf_pkg::ACC_HOLD;
    end else begin
      acc_op_r <= cmd.uop.acc;
    end
    prod_r <= opa * opb;
    sh_r   <= cmd.uop.sh;
    unique case (acc_op_r)
      tbpf_pkg::ACC_HOLD:    acc_r <= acc_r;
      tbpf_pkg::ACC_LOAD:    acc_r <= shifted;
      tbpf_pkg::ACC_LOADNEG: acc_r <= -shifted;
      tbpf_pkg::ACC_ADD:     acc_r <= acc_r + shifted;
      tbpf_pkg::ACC_SUB:     acc_r <= acc_r - shifted;
      default:               acc_r <= acc_r;
    endcase
    unique case (cmd.uop.lt)
      tbpf_pkg::LT_NONE: ;
      tbpf_pkg::LT_P1:   p1_r <= acc_pos;
      tbpf_pkg::LT_P2:   p2_r <= acc_pos;
      tbpf_pkg::LT_CR: begin
        side_r  <= cmd.outer ? acc_pos : acc_r[AW-1];
        crmag_r <= acc_r[AW-1] ? acc_neg[PW-1:0] : acc_r[PW-1:0];
      end
      tbpf_pkg::LT_LEN:  len_r <= acc_r[PW-1:0];
      tbpf_pkg::LT_M2:   m2_r <= acc_r[tbpf_pkg::M2_W-1:0];
      default: ;
    endcase
  end

  // Accumulator holds cr^2 - m^2*len^2 on the last step.
  assign seg_ok = side_r && p1_r && p2_r && acc_pos;

`ifndef SYNTHESIS
  a_len_non_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.uop.lt == tbpf_pkg::LT_LEN) |-> !acc_r[AW-1])
    else $error("squared length came out negative");
`endif

endmodule
`default_nettype wire

/* sv/tbpf_ctrl.sv */
// Controller: input handshake, segment sequencing over both tables, result register.
`default_nettype none
module tbpf_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [tbpf_pkg::CMD_W-1:0]    in_command,
  output logic                               in_stall,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  input  wire tbpf_pkg::ctl_sts_t            sts,
  output tbpf_pkg::ctl_cmd_t                 cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_RD_A, ST_RD_B, ST_DIFF, ST_MUL, ST_EMIT
  } state_t;

  state_t                        state_r;
  logic [tbpf_pkg::STEP_W-1:0]   step_r;
  logic [1:0]                    seg_r;
  logic                          outer_r;
  logic                          out_valid_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.uop     = '{mp: tbpf_pkg::MP_PAX_DX, acc: tbpf_pkg::ACC_HOLD,
                    sh: tbpf_pkg::SH_0, lt: tbpf_pkg::LT_NONE};
    cmd.outer   = outer_r;
    cmd.off     = seg_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        cmd.start   = in_valid && in_command == tbpf_pkg::CMD_CLASSIFY;
      end
      ST_MOD: ;
      ST_RD_A: cmd.rd_en = 1'b1;
      ST_RD_B: begin
        cmd.rd_en = 1'b1;
        cmd.cap_a = 1'b1;
        cmd.off   = seg_r + 2'd1;
      end
      ST_DIFF: cmd.diff = 1'b1;
      ST_MUL:  cmd.uop  = tbpf_pkg::step_uop(step_r);
      ST_EMIT: cmd.emit = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      seg_r       <= '0;
      outer_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, else drop the one just transferred.
      priority if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_command == tbpf_pkg::CMD_CLASSIFY) begin
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (sts.mod_done) begin
            seg_r   <= '0;
            outer_r <= 1'b0;
            state_r <= ST_RD_A;
          end
        end
        ST_RD_A: state_r <= ST_RD_B;
        ST_RD_B: state_r <= ST_DIFF;
        ST_DIFF: begin
          step_r  <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (step_r == tbpf_pkg::STEP_LAST) begin
            // First match on a boundary settles it; move on or finish.
            priority if (sts.seg_ok && !outer_r) begin
              outer_r <= 1'b1;
              seg_r   <= '0;
              state_r <= ST_RD_A;
            end else if (sts.seg_ok) begin
              state_r <= ST_EMIT;
            end else if (seg_r == 2'd2) begin
              state_r <= ST_IDLE;
            end else begin
              seg_r   <= seg_r + 2'd1;
              state_r <= ST_RD_A;
            end
          end else begin
            step_r <= step_r + tbpf_pkg::STEP_W'(1);
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_drop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && step_r == tbpf_pkg::STEP_LAST && !sts.seg_ok
     && seg_r == 2'd2) |=> (state_r == ST_IDLE))
    else $error("no return to idle after last failing segment");
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");
  a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_A) |-> (seg_r != 2'd3))
    else $error("segment counter out of range");
`endif

endmodule
`default_nettype wire

/* sv/track_boundary_point_filter.sv */
// Top level of the track boundary point filter.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  command, vertex_index, coord_x/y/z
//   out_     output     out_valid/out_stall  out_x, out_y, out_z
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Load commands and unused commands are taken in idle. A classify first reduces
// the centre index when it is not below the count (one remainder bit a cycle),
// then per segment: two table reads, a difference state, 16 steps on the
// shared multiplier. Two to six segments and an emit state follow; in_stall holds
// off the next item until the controller is back in idle.
// rst_n is synchronous; the vertex tables are not cleared. A result waits in
// the output register under out_stall while the next item is taken.
`default_nettype none
module track_boundary_point_filter #(
  parameter int FENCE_DEPTH = tbpf_pkg::FENCE_DEPTH_DEF,
  parameter int COORD_WIDTH = tbpf_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [tbpf_pkg::CMD_W-1:0]           in_command,
  input  wire logic [tbpf_pkg::VIDX_W-1:0]          in_vertex_index,
  input  wire logic signed [tbpf_pkg::FIELD_W-1:0]  in_coord_x,
  input  wire logic signed [tbpf_pkg::FIELD_W-1:0]  in_coord_y,
  input  wire logic signed [tbpf_pkg::FIELD_W-1:0]  in_coord_z,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [tbpf_pkg::FIELD_W-1:0]       out_x,
  output logic signed [tbpf_pkg::FIELD_W-1:0]       out_y,
  output logic signed [tbpf_pkg::FIELD_W-1:0]       out_z,
  input  wire logic                                 cfg_we,
  input  wire logic [tbpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tbpf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  tbpf_pkg::ctl_cmd_t              cmd;
  tbpf_pkg::ctl_sts_t              sts;
  logic [$clog2(FENCE_DEPTH)-1:0]  rd_index;
  logic                            mod_done;
  logic                            seg_ok;

  assign sts.mod_done = mod_done;
  assign sts.seg_ok   = seg_ok;

  tbpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  tbpf_addr #(
    .FENCE_DEPTH (FENCE_DEPTH)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .mod_done  (mod_done),
    .rd_index  (rd_index)
  );

  tbpf_dp #(
    .FENCE_DEPTH (FENCE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .cmd             (cmd),
    .rd_index        (rd_index),
    .seg_ok          (seg_ok),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z)
  );

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the track boundary point filter: random corridor traffic against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [tbpf_pkg::CMD_W-1:0]          cmd;
    logic [tbpf_pkg::VIDX_W-1:0]         slot;
    logic signed [tbpf_pkg::FIELD_W-1:0] x;
    logic signed [tbpf_pkg::FIELD_W-1:0] y;
    logic signed [tbpf_pkg::FIELD_W-1:0] z;
  } fence_item_t;

  typedef struct {
    logic signed [tbpf_pkg::FIELD_W-1:0] x;
    logic signed [tbpf_pkg::FIELD_W-1:0] y;
    logic signed [tbpf_pkg::FIELD_W-1:0] z;
  } track_point_t;

  localparam int PITCH  = 2560;  // 10 m between fence vertices
  localparam int WIDTH  = 5120;  // 20 m corridor
  localparam int SETTLE = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [tbpf_pkg::CMD_W-1:0] in_command = tbpf_pkg::CMD_CLASSIFY;
  logic [tbpf_pkg::VIDX_W-1:0] in_vertex_index = '0;
  logic signed [tbpf_pkg::FIELD_W-1:0] in_coord_x = '0;
  logic signed [tbpf_pkg::FIELD_W-1:0] in_coord_y = '0;
  logic signed [tbpf_pkg::FIELD_W-1:0] in_coord_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tbpf_pkg::FIELD_W-1:0] out_x, out_y, out_z;
  logic cfg_we = 1'b0;
  logic [tbpf_pkg::CFG_IDX_W-1:0] cfg_index = tbpf_pkg::CFG_CLOSEST;
  logic [tbpf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  fence_item_t  item_q[$];
  track_point_t kept_q[$];
  int  fails = 0;
  bit  quiet = 1'b0;
  bit  in_took = 1'b0;
  int  gap_cnt = 0;
  int  stall_cnt = 0;

  // predictor state
  logic signed [tbpf_pkg::FIELD_W-1:0] inner_x[tbpf_pkg::FENCE_DEPTH_DEF];
  logic signed [tbpf_pkg::FIELD_W-1:0] inner_y[tbpf_pkg::FENCE_DEPTH_DEF];
  logic signed [tbpf_pkg::FIELD_W-1:0] outer_x[tbpf_pkg::FENCE_DEPTH_DEF];
  logic signed [tbpf_pkg::FIELD_W-1:0] outer_y[tbpf_pkg::FENCE_DEPTH_DEF];
  logic [tbpf_pkg::CI_W-1:0]     centre_r = '0;
  logic [tbpf_pkg::FC_W-1:0]     count_r = tbpf_pkg::FENCE_RST;
  logic [tbpf_pkg::MARGIN_W-1:0] margin_r = tbpf_pkg::MARGIN_RST;

  track_boundary_point_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_vertex_index(in_vertex_index), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic int live_count();
    int n;
    n = count_r;
    if (n < 2) n = 2;
    if (n > tbpf_pkg::FENCE_DEPTH_DEF) n = tbpf_pkg::FENCE_DEPTH_DEF;
    return n;
  endfunction

  function automatic bit segment_clear(bit outer, int ia, int ib, longint px, longint py);
    longint ax, ay, bx, by;
    wide_t dx, dy, pax, pay, pbx, pby, p1, p2, cr, len2, mg;
    ax = outer ? outer_x[ia] : inner_x[ia];
    ay = outer ? outer_y[ia] : inner_y[ia];
    bx = outer ? outer_x[ib] : inner_x[ib];
    by = outer ? outer_y[ib] : inner_y[ib];
    dx = wide_t'(bx - ax);
    dy = wide_t'(by - ay);
    pax = wide_t'(px - ax);
    pay = wide_t'(py - ay);
    pbx = wide_t'(px - bx);
    pby = wide_t'(py - by);
    p1 = pax * dx + pay * dy;
    p2 = -(pbx * dx) - pby * dy;
    cr = pax * pby - pay * pbx;
    len2 = dx * dx + dy * dy;
    mg = wide_t'(margin_r);
    // inner fence wants the point on the right, outer on the left
    if (outer ? !(cr > 0) : !(cr < 0)) return 1'b0;
    if (!(p1 > 0) || !(p2 > 0)) return 1'b0;
    return (cr * cr) > (mg * mg * len2);
  endfunction

  function automatic bit fence_clear(bit outer, longint px, longint py);
    int n, base;
    n = live_count();
    for (int k = 0; k < 3; k++) begin
      base = int'(centre_r) + n + k - 1;
      if (segment_clear(outer, (base - 1) % n, base % n, px, py)) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic classify_point(fence_item_t it);
    track_point_t p;
    case (it.cmd)
      tbpf_pkg::CMD_LOAD_INNER: begin
        inner_x[it.slot] = it.x;
        inner_y[it.slot] = it.y;
      end
      tbpf_pkg::CMD_LOAD_OUTER: begin
        outer_x[it.slot] = it.x;
        outer_y[it.slot] = it.y;
      end
      tbpf_pkg::CMD_CLASSIFY: begin
        if (fence_clear(1'b0, it.x, it.y) && fence_clear(1'b1, it.x, it.y)) begin
          p.x = it.x;
          p.y = it.y;
          p.z = it.z;
          kept_q = {kept_q, p};
        end
      end
      default: ;
    endcase
  endtask

  // sender
  always @(negedge clk) begin
    fence_item_t it;
    if (!in_valid || in_took) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        gap_cnt = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (rst_n && item_q.size() > 0) begin
        it = item_q.pop_front();
        in_valid <= 1'b1;
        in_command <= it.cmd;
        in_vertex_index <= it.slot;
        in_coord_x <= it.x;
        in_coord_y <= it.y;
        in_coord_z <= it.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_cnt = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // accept transfers and check results
  always @(posedge clk) begin
    fence_item_t it;
    track_point_t want;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      it.cmd = in_command;
      it.slot = in_vertex_index;
      it.x = in_coord_x;
      it.y = in_coord_y;
      it.z = in_coord_z;
      classify_point(it);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (kept_q.size() == 0) begin
        $error("unexpected point x=%0d y=%0d z=%0d", out_x, out_y, out_z);
        fails++;
      end else begin
        want = kept_q.pop_front();
        if (out_x !== want.x) begin
          $error("out_x expected %0d actual %0d", want.x, out_x);
          fails++;
        end
        if (out_y !== want.y) begin
          $error("out_y expected %0d actual %0d", want.y, out_y);
          fails++;
        end
        if (out_z !== want.z) begin
          $error("out_z expected %0d actual %0d", want.z, out_z);
          fails++;
        end
      end
    end
  end

  function automatic void push_item(logic [tbpf_pkg::CMD_W-1:0] cmd, int slot, int x, int y,
                                    int z);
    fence_item_t it;
    it.cmd = cmd;
    it.slot = slot[tbpf_pkg::VIDX_W-1:0];
    it.x = x;
    it.y = y;
    it.z = z;
    item_q = {item_q, it};
  endfunction

  function automatic void load_fence(int slot);
    push_item(tbpf_pkg::CMD_LOAD_INNER, slot, slot * PITCH + $urandom_range(0, 600) - 300,
              $urandom_range(0, 600) - 300, $urandom);
    push_item(tbpf_pkg::CMD_LOAD_OUTER, slot, slot * PITCH + $urandom_range(0, 600) - 300,
              -WIDTH + $urandom_range(0, 600) - 300, $urandom);
  endfunction

  function automatic void track_probe(int c);
    push_item(tbpf_pkg::CMD_CLASSIFY, $urandom,
              c * PITCH + $urandom_range(0, 2 * WIDTH) - WIDTH,
              -int'($urandom_range(0, WIDTH)), $urandom);
  endfunction

  task automatic settle();
    do @(posedge clk); while (item_q.size() > 0 || in_valid || kept_q.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [tbpf_pkg::CFG_IDX_W-1:0] idx,
                           logic [tbpf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tbpf_pkg::CFG_CLOSEST: centre_r = val[tbpf_pkg::CI_W-1:0];
      tbpf_pkg::CFG_FENCE:   count_r = val[tbpf_pkg::FC_W-1:0];
      tbpf_pkg::CFG_MARGIN:  margin_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int ci, int fc, int mg, int items);
    int n, c, r;
    settle();
    write_reg(tbpf_pkg::CFG_CLOSEST, ci[tbpf_pkg::CFG_DATA_W-1:0]);
    write_reg(tbpf_pkg::CFG_FENCE, fc[tbpf_pkg::CFG_DATA_W-1:0]);
    write_reg(tbpf_pkg::CFG_MARGIN, mg[tbpf_pkg::CFG_DATA_W-1:0]);
    n = live_count();
    c = int'(centre_r) % n;
    // every slot a classify can touch must be loaded first
    if (n <= 16) begin
      for (int s = 0; s < n; s++) load_fence(s);
    end else begin
      for (int k = -2; k <= 1; k++) load_fence(((c + k) % n + n) % n);
    end
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) track_probe(c);
      else if (r < 85) load_fence(((c + $urandom_range(0, 3) - 2) % n + n) % n);
      else if (r < 90)
        push_item(($urandom_range(0, 1) == 0) ? tbpf_pkg::CMD_LOAD_INNER
                                              : tbpf_pkg::CMD_LOAD_OUTER,
                  $urandom, $urandom, $urandom, 0);
      else if (r < 95)
        push_item(tbpf_pkg::CMD_CLASSIFY, $urandom, $urandom, $urandom, $urandom);
      else push_item(2'd3, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: two vertices, centre 0, margin 1.5 m
    load_fence(0);
    load_fence(1);
    push_item(2'd3, 4095, -1, -1, -1);
    push_item(tbpf_pkg::CMD_LOAD_INNER, 4095, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    push_item(tbpf_pkg::CMD_LOAD_OUTER, 4094, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    push_item(tbpf_pkg::CMD_LOAD_INNER, 12'haaa, 32'sh5555_5555, 32'shaaaa_aaaa, 0);
    push_item(tbpf_pkg::CMD_LOAD_OUTER, 12'h555, 32'shaaaa_aaaa, 32'sh5555_5555, 0);
    push_item(tbpf_pkg::CMD_CLASSIFY, 4095, PITCH / 2, -WIDTH / 2, 32'sh7fff_ffff);
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, PITCH / 2, -WIDTH / 2, 32'sh8000_0000);
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, 32'sh8000_0000, 32'sh8000_0000, 0);
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, -1);
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, 0, 0, 5);                // on a vertex
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, PITCH / 2, -100, 6);     // inside the margin
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, PITCH / 2, 1000, 7);     // wrong side of inner
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, -PITCH, -WIDTH / 2, 8);  // projects before it
    settle();
    write_reg(2'd3, 16'hffff);  // no such register
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, PITCH / 2, -WIDTH / 2, 9);

    // degenerate fence: both inner vertices at one spot
    run_phase(0, 2, 0, 0);
    push_item(tbpf_pkg::CMD_LOAD_INNER, 0, 100, 100, 0);
    push_item(tbpf_pkg::CMD_LOAD_INNER, 1, 100, 100, 0);
    push_item(tbpf_pkg::CMD_CLASSIFY, 0, 500, -500, 1);

    run_phase(16'hffff, 3, 0, 100);
    run_phase(0, 4096, 65535, 60);
    run_phase(4095, 8191, 384, 100);
    run_phase(5, 0, 1, 100);
    run_phase(4094, 16'hffff, 0, 80);
    for (int p = 0; p < 7; p++) begin
      run_phase($urandom_range(0, 4095),
                ($urandom_range(0, 3) == 0) ? $urandom_range(17, 8191) : $urandom_range(2, 12),
                $urandom_range(0, 1000), 100);
      if (p == 3) begin
        // hold the sender until every kept point is out
        settle();
        track_probe(int'(centre_r) % live_count());
      end
    end
    settle();
    quiet = 1'b1;
    run_phase($urandom_range(0, 4095), $urandom_range(2, 9), 384, 100);
    settle();
    if (fails == 0) begin
      $display("track_boundary_point_filter test passed");
    end else begin
      $display("track_boundary_point_filter test failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("track_boundary_point_filter test failed");
    $finish;
  end

endmodule
`default_nettype wire
